FILE: rtl/bgpevpn_pkg.sv
// Shared types and constants for the BGP UPDATE EVPN attribute parser.
`default_nettype none

package bgpevpn_pkg;

  // Parse phase of the UPDATE body walk.
  typedef enum logic [3:0] {
    PH_WLEN    = 4'd0,
    PH_WSKIP   = 4'd1,
    PH_ALEN    = 4'd2,
    PH_AFLAGS  = 4'd3,
    PH_ATYPE   = 4'd4,
    PH_ALENGTH = 4'd5,
    PH_AVALUE  = 4'd6,
    PH_ASKIP   = 4'd7,
    PH_TRAIL   = 4'd8
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_REACH   = 2'd0;
  localparam logic [1:0] KIND_UNREACH = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_HDR      = 2'd2;
  localparam logic [1:0] ST_OVERRUN  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_IDX_FAMILY    = 1'b0;
  localparam logic CFG_IDX_SUBFAMILY = 1'b1;

  localparam logic [15:0] FAMILY_RESET    = 16'd25;
  localparam logic [7:0]  SUBFAMILY_RESET = 8'd70;

  // Attribute types and length limits.
  localparam logic [7:0]  ATTR_NEXTHOP    = 8'd3;
  localparam logic [7:0]  ATTR_MP_REACH   = 8'd14;
  localparam logic [7:0]  ATTR_MP_UNREACH = 8'd15;
  localparam int unsigned EXT_FLAG_BIT    = 4;
  localparam logic [15:0] REACH_MIN       = 16'd5;
  localparam logic [15:0] UNREACH_MIN     = 16'd3;
  localparam logic [7:0]  HOP_SHORT       = 8'd4;
  localparam logic [7:0]  HOP_LONG        = 8'd16;
  localparam logic [15:0] HOP_OFFSET      = 16'd4;
  localparam logic [15:0] HOP_KEEP_END    = 16'd8;
  localparam logic [15:0] HDR_MIN         = 16'd3;
  localparam logic [15:0] HDR_MIN_EXT     = 16'd4;

  // Result queue depth; an input byte can cause two results.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  nlri_byte;
    logic        run_start;
    logic [31:0] hop_addr;
    logic [1:0]  status;
    logic        reach_found;
    logic        unreach_found;
    logic [15:0] reach_length;
    logic [15:0] unreach_length;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/bgp_update_evpn_attribute_parser_core.sv
// BGP UPDATE body parser that streams EVPN NLRI bytes and reports a per-message status.
//
// Usage: the UPDATE body (after the 19-byte header) enters one byte per
// transfer on the in_ channel, with in_end_of_message set on the final byte.
// Each byte is parsed in the cycle of its transfer; the results it causes
// (an NLRI byte of a matching MP_REACH or MP_UNREACH attribute, and on the
// final byte a status item) are written into a four-entry result queue that
// drives the out_ channel directly; a result is registered before it reaches
// out_. The block takes one byte per cycle while in_ready is high; the final
// byte of a message may cause two results, which leave one after the other.
// in_ready drops while fewer than two queue entries are free, so a stalled
// receiver holds back the sender after at most four buffered results and
// nothing is lost. The cfg_ port writes the family or the subfamily match
// register selected by cfg_index. Reset clears the parse state and empties
// the queue, and the match registers return to 25 and 70. After each message
// the parse state returns to its reset value; the match registers stay.
`default_nettype none

module bgp_update_evpn_attribute_parser_core
  import bgpevpn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_nlri_byte,
  output logic             out_run_start,
  output logic [31:0]      out_hop_addr,
  output logic [1:0]       out_status,
  output logic             out_reach_found,
  output logic             out_unreach_found,
  output logic [15:0]      out_reach_length,
  output logic [15:0]      out_unreach_length,
  output logic             out_last,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration.
  logic [15:0] family_r;
  logic [7:0]  subfamily_r;

  // Parse state.
  phase_t      phase_r, phase_nxt;
  logic        hi_r, hi_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] sec_left_r, sec_left_nxt;
  logic        ext_r, ext_nxt;
  logic [7:0]  attr_type_r, attr_type_nxt;
  logic [15:0] attr_size_r, attr_size_nxt;
  logic [15:0] off_r, off_nxt;
  logic [4:0]  hop_len_r, hop_len_nxt;
  logic [15:0] afi_r, afi_nxt;
  logic [7:0]  safi_r, safi_nxt;
  logic [31:0] hop_val_r, hop_val_nxt;
  logic        reach_seen_r, reach_seen_nxt;
  logic [15:0] reach_cnt_r, reach_cnt_nxt;
  logic        unreach_seen_r, unreach_seen_nxt;
  logic [15:0] unreach_cnt_r, unreach_cnt_nxt;
  logic [1:0]  err_r, err_nxt;

  // Result queue.
  result_t          rq_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_AW:0]   rq_cnt_r;

  logic        in_acc, pop;
  logic [7:0]  b;
  logic        fam_match;
  logic        reach_attr, unreach_attr;
  logic [15:0] nlri_start;
  logic        emit, emit_run;
  logic [1:0]  emit_kind;
  result_t     nlri_item, status_item;
  logic        push_a, push_b;
  logic [1:0]  push_cnt;

  assign b         = in_data_byte;
  assign in_acc    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (rq_cnt_r <= (RQ_AW+1)'(RQ_DEPTH - 2));
  assign out_valid = (rq_cnt_r != '0);

  assign fam_match    = (afi_r == family_r) && (safi_r == subfamily_r);
  assign reach_attr   = (attr_type_r == ATTR_MP_REACH) && (attr_size_r >= REACH_MIN);
  assign unreach_attr = (attr_type_r == ATTR_MP_UNREACH) && (attr_size_r >= UNREACH_MIN);
  assign nlri_start   = REACH_MIN + {11'd0, hop_len_r};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      family_r    <= FAMILY_RESET;
      subfamily_r <= SUBFAMILY_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_IDX_FAMILY:    family_r    <= cfg_data;
        CFG_IDX_SUBFAMILY: subfamily_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Next parse state for the byte on the input.
  always_comb begin
    logic [15:0] len_v;
    logic        hop_ok;

    phase_nxt        = phase_r;
    hi_nxt           = hi_r;
    len_hi_nxt       = len_hi_r;
    cnt_nxt          = cnt_r;
    sec_left_nxt     = sec_left_r;
    ext_nxt          = ext_r;
    attr_type_nxt    = attr_type_r;
    attr_size_nxt    = attr_size_r;
    off_nxt          = off_r;
    hop_len_nxt      = hop_len_r;
    afi_nxt          = afi_r;
    safi_nxt         = safi_r;
    hop_val_nxt      = hop_val_r;
    reach_seen_nxt   = reach_seen_r;
    reach_cnt_nxt    = reach_cnt_r;
    unreach_seen_nxt = unreach_seen_r;
    unreach_cnt_nxt  = unreach_cnt_r;
    err_nxt          = err_r;
    len_v            = ext_r ? {attr_size_r[15:8], b} : {8'd0, b};
    hop_ok           = ((b == HOP_SHORT) || (b == HOP_LONG)) &&
                       (attr_size_r >= REACH_MIN + {8'd0, b});

    unique case (phase_r)
      PH_WLEN: begin
        if (!hi_r) begin
          len_hi_nxt = b;
          hi_nxt     = 1'b1;
        end else begin
          hi_nxt  = 1'b0;
          cnt_nxt = {len_hi_r, b};
          phase_nxt = ({len_hi_r, b} == 16'd0) ? PH_ALEN : PH_WSKIP;
        end
      end
      PH_WSKIP: begin
        // Counts down the withdrawn-routes bytes still to skip.
        cnt_nxt = cnt_r - 16'd1;
        if (cnt_r == 16'd1) phase_nxt = PH_ALEN;
      end
      PH_ALEN: begin
        if (!hi_r) begin
          len_hi_nxt = b;
          hi_nxt     = 1'b1;
        end else begin
          hi_nxt       = 1'b0;
          sec_left_nxt = {len_hi_r, b};
          phase_nxt    = ({len_hi_r, b} == 16'd0) ? PH_TRAIL : PH_AFLAGS;
        end
      end
      PH_AFLAGS, PH_ATYPE, PH_ALENGTH, PH_AVALUE, PH_ASKIP: begin
        case (phase_r)
          PH_AFLAGS: begin
            ext_nxt = b[EXT_FLAG_BIT];
            if ((sec_left_r < HDR_MIN) || (b[EXT_FLAG_BIT] && (sec_left_r < HDR_MIN_EXT))) begin
              if (err_r == ST_OK) err_nxt = ST_HDR;
              phase_nxt = PH_ASKIP;
            end else begin
              phase_nxt = PH_ATYPE;
            end
          end
          PH_ATYPE: begin
            attr_type_nxt = b;
            hi_nxt        = 1'b0;
            phase_nxt     = PH_ALENGTH;
          end
          PH_ALENGTH: begin
            if (ext_r && !hi_r) begin
              attr_size_nxt = {b, 8'd0};
              hi_nxt        = 1'b1;
            end else begin
              attr_size_nxt = len_v;
              hi_nxt        = 1'b0;
              if (len_v > sec_left_r - 16'd1) begin
                if (err_r == ST_OK) err_nxt = ST_OVERRUN;
                phase_nxt = PH_ASKIP;
              end else begin
                off_nxt     = 16'd0;
                hop_len_nxt = 5'd0;
                phase_nxt   = (len_v != 16'd0) ? PH_AVALUE : PH_AFLAGS;
              end
            end
          end
          PH_AVALUE: begin
            if (attr_type_r == ATTR_NEXTHOP) begin
              if (attr_size_r == 16'd4) hop_val_nxt = {hop_val_r[23:0], b};
            end else if (reach_attr) begin
              if (off_r == 16'd0) begin
                afi_nxt = {b, 8'd0};
              end else if (off_r == 16'd1) begin
                afi_nxt = {afi_r[15:8], b};
              end else if (off_r == 16'd2) begin
                safi_nxt = b;
              end else if (off_r == 16'd3) begin
                if (hop_ok) begin
                  hop_len_nxt    = b[4:0];
                  reach_seen_nxt = fam_match;
                  reach_cnt_nxt  = fam_match ? (attr_size_r - REACH_MIN - {8'd0, b}) : 16'd0;
                end else begin
                  hop_len_nxt = 5'd0;
                end
              end else if ((hop_len_r != 5'd0) && (off_r < HOP_KEEP_END)) begin
                // Only the first four next-hop bytes are kept.
                hop_val_nxt = {hop_val_r[23:0], b};
              end
            end else if (unreach_attr) begin
              if (off_r == 16'd0) begin
                afi_nxt = {b, 8'd0};
              end else if (off_r == 16'd1) begin
                afi_nxt = {afi_r[15:8], b};
              end else if (off_r == 16'd2) begin
                safi_nxt          = b;
                unreach_seen_nxt  = (afi_r == family_r) && (b == subfamily_r);
                unreach_cnt_nxt   = ((afi_r == family_r) && (b == subfamily_r)) ?
                                    (attr_size_r - UNREACH_MIN) : 16'd0;
              end
            end
            off_nxt = off_r + 16'd1;
            if (off_r + 16'd1 >= attr_size_r) phase_nxt = PH_AFLAGS;
          end
          default: ;
        endcase
        // The last section byte ends the attribute walk whatever else happened.
        sec_left_nxt = sec_left_r - 16'd1;
        if (sec_left_r == 16'd1) phase_nxt = PH_TRAIL;
      end
      PH_TRAIL: ;
      default: ;
    endcase
  end

  // Result items for the byte on the input.
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_REACH;
    emit_run  = 1'b0;
    if (phase_r == PH_AVALUE) begin
      if (reach_attr && (hop_len_r != 5'd0) && (off_r >= HOP_OFFSET) &&
          (off_r >= nlri_start) && fam_match) begin
        emit      = 1'b1;
        emit_kind = KIND_REACH;
        emit_run  = (off_r == nlri_start);
      end else if (unreach_attr && (off_r >= UNREACH_MIN) && fam_match) begin
        emit      = 1'b1;
        emit_kind = KIND_UNREACH;
        emit_run  = (off_r == UNREACH_MIN);
      end
    end

    nlri_item                = '0;
    nlri_item.kind           = emit_kind;
    nlri_item.nlri_byte      = b;
    nlri_item.run_start      = emit_run;
    nlri_item.last           = !in_end_of_message;

    status_item                = '0;
    status_item.kind           = KIND_STATUS;
    status_item.hop_addr       = hop_val_nxt;
    status_item.status         = (phase_nxt != PH_TRAIL) ? ST_SHORT : err_nxt;
    status_item.reach_found    = reach_seen_nxt;
    status_item.unreach_found  = unreach_seen_nxt;
    status_item.reach_length   = reach_cnt_nxt;
    status_item.unreach_length = unreach_cnt_nxt;
    status_item.last           = 1'b1;
  end

  assign push_a   = in_acc && emit;
  assign push_b   = in_acc && in_end_of_message;
  assign push_cnt = {1'b0, push_a} + {1'b0, push_b};

  // Parse state registers; the end of a message returns them to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_end_of_message)) begin
      phase_r        <= PH_WLEN;
      hi_r           <= 1'b0;
      len_hi_r       <= '0;
      cnt_r          <= '0;
      sec_left_r     <= '0;
      ext_r          <= 1'b0;
      attr_type_r    <= '0;
      attr_size_r    <= '0;
      off_r          <= '0;
      hop_len_r      <= '0;
      afi_r          <= '0;
      safi_r         <= '0;
      hop_val_r      <= '0;
      reach_seen_r   <= 1'b0;
      reach_cnt_r    <= '0;
      unreach_seen_r <= 1'b0;
      unreach_cnt_r  <= '0;
      err_r          <= ST_OK;
    end else if (in_acc) begin
      phase_r        <= phase_nxt;
      hi_r           <= hi_nxt;
      len_hi_r       <= len_hi_nxt;
      cnt_r          <= cnt_nxt;
      sec_left_r     <= sec_left_nxt;
      ext_r          <= ext_nxt;
      attr_type_r    <= attr_type_nxt;
      attr_size_r    <= attr_size_nxt;
      off_r          <= off_nxt;
      hop_len_r      <= hop_len_nxt;
      afi_r          <= afi_nxt;
      safi_r         <= safi_nxt;
      hop_val_r      <= hop_val_nxt;
      reach_seen_r   <= reach_seen_nxt;
      reach_cnt_r    <= reach_cnt_nxt;
      unreach_seen_r <= unreach_seen_nxt;
      unreach_cnt_r  <= unreach_cnt_nxt;
      err_r          <= err_nxt;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (push_a) rq_r[wr_ptr_r] <= nlri_item;
    if (push_b) rq_r[push_a ? (wr_ptr_r + RQ_AW'(1)) : wr_ptr_r] <= status_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      rq_cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + RQ_AW'(push_cnt);
      if (pop) rd_ptr_r <= rd_ptr_r + RQ_AW'(1);
      rq_cnt_r <= rq_cnt_r + (RQ_AW+1)'(push_cnt) - (RQ_AW+1)'(pop);
    end
  end

  assign out_kind           = rq_r[rd_ptr_r].kind;
  assign out_nlri_byte      = rq_r[rd_ptr_r].nlri_byte;
  assign out_run_start      = rq_r[rd_ptr_r].run_start;
  assign out_hop_addr       = rq_r[rd_ptr_r].hop_addr;
  assign out_status         = rq_r[rd_ptr_r].status;
  assign out_reach_found    = rq_r[rd_ptr_r].reach_found;
  assign out_unreach_found  = rq_r[rd_ptr_r].unreach_found;
  assign out_reach_length   = rq_r[rd_ptr_r].reach_length;
  assign out_unreach_length = rq_r[rd_ptr_r].unreach_length;
  assign out_last           = rq_r[rd_ptr_r].last;

  // The queue never holds more results than it has entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    rq_cnt_r <= (RQ_AW+1)'(RQ_DEPTH))
    else $error("result queue overflow");

  // The final byte of a message always returns the parser to its start.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_message) |=> (phase_r == PH_WLEN) && (err_r == ST_OK))
    else $error("parse state not cleared after end of message");

  // Inside the attribute section at least one section byte is still due.
  assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_AFLAGS) || (phase_r == PH_ATYPE) || (phase_r == PH_ALENGTH) ||
     (phase_r == PH_AVALUE) || (phase_r == PH_ASKIP)) |-> (sec_left_r != 16'd0))
    else $error("attribute section walked past its end");

  // While a value is being read, its offset stays below the attribute length.
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_AVALUE) |-> (off_r < attr_size_r))
    else $error("value offset beyond attribute length");

  // A status result is always the last result of its byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_STATUS)) |-> out_last)
    else $error("status result not marked last");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the BGP UPDATE EVPN attribute parser core.
`timescale 1ns / 1ps

module tb
  import bgpevpn_pkg::*;
();

  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 350;
  localparam int SCRIPT_ROWS   = 31;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 4;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_nlri_byte;
  logic        out_run_start;
  logic [31:0] out_hop_addr;
  logic [1:0]  out_status;
  logic        out_reach_found;
  logic        out_unreach_found;
  logic [15:0] out_reach_length;
  logic [15:0] out_unreach_length;
  logic        out_last;
  logic        cfg_write_en = 1'b0;
  logic        cfg_index = CFG_IDX_FAMILY;
  logic [15:0] cfg_data = 16'h0000;

  bgp_update_evpn_attribute_parser_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_end_of_message  (in_end_of_message),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_nlri_byte      (out_nlri_byte),
    .out_run_start      (out_run_start),
    .out_hop_addr       (out_hop_addr),
    .out_status         (out_status),
    .out_reach_found    (out_reach_found),
    .out_unreach_found  (out_unreach_found),
    .out_reach_length   (out_reach_length),
    .out_unreach_length (out_unreach_length),
    .out_last           (out_last),
    .cfg_write_en       (cfg_write_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed script: typed status codes apply to the final byte of a message only.
  typedef struct packed {
    logic [7:0] data;
    logic       eom;
    logic       typed;
    logic [1:0] st;
  } script_row_t;

  script_row_t script_rows [SCRIPT_ROWS] = '{
    // Body ends inside the withdrawn length.
    {8'hFF, 1'b1, 1'b1, ST_SHORT},
    // Empty attribute section with one trailing byte.
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'hFF, 1'b1, 1'b1, ST_OK},
    // Extended length flag with only three section bytes left.
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h03, 1'b0, 1'b0, ST_OK},
    {8'h10, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'h00, 1'b1, 1'b1, ST_HDR},
    // Attribute length runs past the section.
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h03, 1'b0, 1'b0, ST_OK},
    {8'h40, 1'b0, 1'b0, ST_OK}, {8'h01, 1'b0, 1'b0, ST_OK},
    {8'h05, 1'b1, 1'b1, ST_OVERRUN},
    // Matching MP_UNREACH whose single NLRI byte is the final body byte.
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'h00, 1'b0, 1'b0, ST_OK}, {8'h07, 1'b0, 1'b0, ST_OK},
    {8'h80, 1'b0, 1'b0, ST_OK}, {8'h0F, 1'b0, 1'b0, ST_OK},
    {8'h04, 1'b0, 1'b0, ST_OK}, {8'h00, 1'b0, 1'b0, ST_OK},
    {8'h19, 1'b0, 1'b0, ST_OK}, {8'h46, 1'b0, 1'b0, ST_OK},
    {8'hAB, 1'b1, 1'b0, ST_OK}
  };

  // Parser state mirrored by the predictor.
  phase_t      walk_phase;
  logic [15:0] walk_pos, wd_total, sec_total, sec_used;
  logic        ext_len;
  logic [7:0]  attr_type;
  logic [15:0] attr_size, val_off;
  logic [7:0]  hop_len;
  logic [15:0] seen_afi;
  logic [7:0]  seen_safi;
  logic [31:0] hop_addr;
  logic        reach_seen, unreach_seen;
  logic [15:0] reach_cnt, unreach_cnt;
  logic [1:0]  first_err;
  logic [15:0] cfg_family;
  logic [7:0]  cfg_subfamily;

  result_t     step_results [$];
  result_t     awaited [$];
  logic [7:0]  msg_bytes [$];
  logic [7:0]  attr_bytes [$];
  int          fail_count = 0;
  int          ready_hold = 0;
  int          pick;
  result_t     got, want;

  function automatic void clear_walk();
    walk_phase = PH_WLEN;
    walk_pos = '0; wd_total = '0; sec_total = '0; sec_used = '0;
    ext_len = 1'b0; attr_type = '0; attr_size = '0; val_off = '0; hop_len = '0;
    seen_afi = '0; seen_safi = '0; hop_addr = '0;
    reach_seen = 1'b0; reach_cnt = '0; unreach_seen = 1'b0; unreach_cnt = '0;
    first_err = ST_OK;
  endfunction

  function automatic void flag_error(input logic [1:0] code);
    if (first_err == ST_OK) first_err = code;
    walk_phase = PH_ASKIP;
  endfunction

  function automatic logic family_hit();
    return seen_afi == cfg_family && seen_safi == cfg_subfamily;
  endfunction

  // Advances the mirrored parser by one body byte and leaves its results in step_results.
  function automatic void parse_update_byte(input logic [7:0] b, input logic eom);
    logic        emit;
    logic [1:0]  ekind;
    logic        erun;
    logic        done;
    logic [15:0] left;
    logic [15:0] off;
    result_t     r;
    emit = 1'b0;
    ekind = KIND_REACH;
    erun = 1'b0;
    step_results.delete();
    case (walk_phase)
      PH_WLEN: begin
        if (walk_pos == 0) begin
          wd_total = {b, 8'h00};
          walk_pos = 16'd1;
        end else begin
          wd_total = wd_total | {8'h00, b};
          walk_pos = '0;
          if (wd_total != 0) walk_phase = PH_WSKIP;
          else walk_phase = PH_ALEN;
        end
      end
      PH_WSKIP: begin
        walk_pos = walk_pos + 16'd1;
        if (walk_pos >= wd_total) begin
          walk_pos = '0;
          walk_phase = PH_ALEN;
        end
      end
      PH_ALEN: begin
        if (walk_pos == 0) begin
          sec_total = {b, 8'h00};
          walk_pos = 16'd1;
        end else begin
          sec_total = sec_total | {8'h00, b};
          walk_pos = '0;
          sec_used = '0;
          if (sec_total != 0) walk_phase = PH_AFLAGS;
          else walk_phase = PH_TRAIL;
        end
      end
      PH_AFLAGS, PH_ATYPE, PH_ALENGTH, PH_AVALUE, PH_ASKIP: begin
        left = sec_total - sec_used;
        case (walk_phase)
          PH_AFLAGS: begin
            ext_len = b[EXT_FLAG_BIT];
            if (left < HDR_MIN || (ext_len && left < HDR_MIN_EXT)) flag_error(ST_HDR);
            else walk_phase = PH_ATYPE;
          end
          PH_ATYPE: begin
            attr_type = b;
            walk_pos = '0;
            walk_phase = PH_ALENGTH;
          end
          PH_ALENGTH: begin
            done = 1'b1;
            if (ext_len && walk_pos == 0) begin
              attr_size = {b, 8'h00};
              walk_pos = 16'd1;
              done = 1'b0;
            end else if (ext_len) begin
              attr_size = attr_size | {8'h00, b};
              walk_pos = '0;
            end else begin
              attr_size = {8'h00, b};
            end
            if (done) begin
              if (attr_size > left - 16'd1) begin
                flag_error(ST_OVERRUN);
              end else begin
                val_off = '0;
                hop_len = '0;
                if (attr_size != 0) walk_phase = PH_AVALUE;
                else walk_phase = PH_AFLAGS;
              end
            end
          end
          PH_AVALUE: begin
            off = val_off;
            if (attr_type == ATTR_NEXTHOP) begin
              if (attr_size == 16'd4) hop_addr = {hop_addr[23:0], b};
            end else if (attr_type == ATTR_MP_REACH && attr_size >= REACH_MIN) begin
              if (off == 0) seen_afi = {b, 8'h00};
              else if (off == 1) seen_afi = seen_afi | {8'h00, b};
              else if (off == 2) seen_safi = b;
              else if (off == 3) begin
                if ((b == HOP_SHORT || b == HOP_LONG) && attr_size >= REACH_MIN + b) begin
                  hop_len = b;
                  if (family_hit()) begin
                    reach_seen = 1'b1;
                    reach_cnt = attr_size - REACH_MIN - b;
                  end else begin
                    reach_seen = 1'b0;
                    reach_cnt = '0;
                  end
                end else begin
                  hop_len = '0;
                end
              end else if (hop_len != 0) begin
                if (off < HOP_KEEP_END) hop_addr = {hop_addr[23:0], b};
                if (off >= REACH_MIN + hop_len && family_hit()) begin
                  emit = 1'b1;
                  ekind = KIND_REACH;
                  erun = (off == REACH_MIN + hop_len);
                end
              end
            end else if (attr_type == ATTR_MP_UNREACH && attr_size >= UNREACH_MIN) begin
              if (off == 0) seen_afi = {b, 8'h00};
              else if (off == 1) seen_afi = seen_afi | {8'h00, b};
              else if (off == 2) begin
                seen_safi = b;
                if (family_hit()) begin
                  unreach_seen = 1'b1;
                  unreach_cnt = attr_size - UNREACH_MIN;
                end else begin
                  unreach_seen = 1'b0;
                  unreach_cnt = '0;
                end
              end else if (family_hit()) begin
                emit = 1'b1;
                ekind = KIND_UNREACH;
                erun = (off == UNREACH_MIN);
              end
            end
            val_off = off + 16'd1;
            if (val_off >= attr_size) walk_phase = PH_AFLAGS;
          end
          default: begin
          end
        endcase
        sec_used = sec_used + 16'd1;
        if (sec_used >= sec_total) walk_phase = PH_TRAIL;
      end
      default: begin
      end
    endcase

    if (emit) begin
      r = '0;
      r.kind = ekind;
      r.nlri_byte = b;
      r.run_start = erun;
      r.last = !eom;
      step_results.push_back(r);
    end
    if (eom) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.hop_addr = hop_addr;
      // A body that stops before the section is complete is short, whatever else failed.
      if (walk_phase != PH_TRAIL && walk_phase <= PH_ASKIP) r.status = ST_SHORT;
      else r.status = first_err;
      r.reach_found = reach_seen;
      r.unreach_found = unreach_seen;
      r.reach_length = reach_cnt;
      r.unreach_length = unreach_cnt;
      r.last = 1'b1;
      step_results.push_back(r);
      clear_walk();
    end
  endfunction

  function automatic void add_path_attribute();
    logic [7:0] val [$];
    logic [7:0] flags;
    logic [7:0] code;
    logic [15:0] afi_v;
    logic [7:0] safi_v;
    logic [7:0] hop;
    int n;
    afi_v = ($urandom_range(0, 99) < 85) ? cfg_family : 16'($urandom);
    safi_v = ($urandom_range(0, 99) < 85) ? cfg_subfamily : 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        code = ATTR_NEXTHOP;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 4;
        repeat (n) val.push_back(8'($urandom));
      end
      2, 3, 4: begin
        code = ATTR_MP_REACH;
        hop = ($urandom_range(0, 2) == 0) ? HOP_LONG : HOP_SHORT;
        val.push_back(afi_v[15:8]);
        val.push_back(afi_v[7:0]);
        val.push_back(safi_v);
        val.push_back(hop);
        repeat (hop + 1) val.push_back(8'($urandom));
        repeat ($urandom_range(0, 6)) val.push_back(8'($urandom));
      end
      5: begin
        code = ATTR_MP_REACH;
        case ($urandom_range(0, 2))
          0: repeat ($urandom_range(0, 4)) val.push_back(8'($urandom));
          1: begin
            val.push_back(afi_v[15:8]);
            val.push_back(afi_v[7:0]);
            val.push_back(safi_v);
            val.push_back(8'($urandom));
            repeat ($urandom_range(0, 20)) val.push_back(8'($urandom));
          end
          default: begin
            // Long hop that does not fit in the attribute.
            val.push_back(afi_v[15:8]);
            val.push_back(afi_v[7:0]);
            val.push_back(safi_v);
            val.push_back(HOP_LONG);
            repeat ($urandom_range(1, 16)) val.push_back(8'($urandom));
          end
        endcase
      end
      6, 7: begin
        code = ATTR_MP_UNREACH;
        val.push_back(afi_v[15:8]);
        val.push_back(afi_v[7:0]);
        val.push_back(safi_v);
        repeat ($urandom_range(0, 6)) val.push_back(8'($urandom));
      end
      8: begin
        code = ATTR_MP_UNREACH;
        repeat ($urandom_range(0, 2)) val.push_back(8'($urandom));
      end
      default: begin
        code = 8'($urandom);
        repeat ($urandom_range(0, 5)) val.push_back(8'($urandom));
      end
    endcase
    flags = 8'($urandom);
    flags[EXT_FLAG_BIT] = ($urandom_range(0, 3) == 0);
    attr_bytes.push_back(flags);
    attr_bytes.push_back(code);
    if (flags[EXT_FLAG_BIT]) attr_bytes.push_back(8'h00);
    attr_bytes.push_back(8'(val.size()));
    foreach (val[k]) attr_bytes.push_back(val[k]);
  endfunction

  // Builds one UPDATE body: mostly well formed, some with a wrong section length,
  // some cut short, a few pure noise.
  function automatic void compose_update();
    int mode, wlen, slen, cut;
    msg_bytes.delete();
    attr_bytes.delete();
    mode = $urandom_range(0, 99);
    if (mode < 6) begin
      repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
    end else begin
      wlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      msg_bytes.push_back(8'(wlen >> 8));
      msg_bytes.push_back(8'(wlen));
      repeat (wlen) msg_bytes.push_back(8'($urandom));
      repeat ($urandom_range(0, 4)) add_path_attribute();
      slen = attr_bytes.size();
      if (mode < 16) slen = slen + int'($urandom_range(0, 6)) - 3;
      if (slen < 0) slen = 0;
      msg_bytes.push_back(8'(slen >> 8));
      msg_bytes.push_back(8'(slen));
      foreach (attr_bytes[k]) msg_bytes.push_back(attr_bytes[k]);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
      if (mode < 24 && mode >= 16 && msg_bytes.size() > 1) begin
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
    end
  endfunction

  function automatic int pick_gap(input logic burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic string result_text(input result_t r);
    return $sformatf("kind=%0d byte=%h run=%0d hop=%h st=%0d rf=%0d uf=%0d rl=%0d ul=%0d last=%0d",
                     r.kind, r.nlri_byte, r.run_start, r.hop_addr, r.status, r.reach_found,
                     r.unreach_found, r.reach_length, r.unreach_length, r.last);
  endfunction

  task automatic note_failure(input string what, input result_t exp_r, input result_t act_r);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
      $display("  expected %s", result_text(exp_r));
      $display("  actual   %s", result_text(act_r));
    end
  endtask

  // Drives one body byte, waits for its transfer and records the results it causes.
  task automatic send_byte(input logic [7:0] b, input logic eom, input int gap,
                           input logic typed, input logic [1:0] typed_st);
    result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_update_byte(b, eom);
    if (typed) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.status = typed_st;
      r.last = 1'b1;
      awaited.push_back(r);
    end else begin
      foreach (step_results[k]) awaited.push_back(step_results[k]);
    end
  endtask

  task automatic wait_drained();
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_match_regs(input logic [15:0] family, input logic [7:0] subfamily);
    logic [7:0] junk;
    junk = 8'($urandom);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_IDX_FAMILY;
    cfg_data <= family;
    @(posedge clk);
    cfg_index <= CFG_IDX_SUBFAMILY;
    cfg_data <= {junk, subfamily};
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_family = family;
    cfg_subfamily = subfamily;
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = {out_kind, out_nlri_byte, out_run_start, out_hop_addr, out_status,
             out_reach_found, out_unreach_found, out_reach_length, out_unreach_length,
             out_last};
      if (awaited.size() == 0) begin
        note_failure("result transfer with nothing expected", '0, got);
      end else begin
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.nlri_byte !== want.nlri_byte ||
            got.run_start !== want.run_start || got.hop_addr !== want.hop_addr ||
            got.status !== want.status || got.reach_found !== want.reach_found ||
            got.unreach_found !== want.unreach_found ||
            got.reach_length !== want.reach_length ||
            got.unreach_length !== want.unreach_length || got.last !== want.last) begin
          note_failure("result mismatch", want, got);
        end
      end
    end
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(0, 7);
      end else if (pick < 70) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(30, 150);
      end else if (pick < 93) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(20, 60);
      end
    end
  end

  // Ends the run when neither channel has moved a transfer for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int sent;
    logic burst;
    clear_walk();
    cfg_family = FAMILY_RESET;
    cfg_subfamily = SUBFAMILY_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_byte(script_rows[i].data, script_rows[i].eom, pick_gap(1'b0),
                script_rows[i].typed, script_rows[i].st);
    end

    for (int ph = 0; ph < 4; ph++) begin
      if (ph != 0) begin
        in_valid <= 1'b0;
        wait_drained();
        case (ph)
          1: write_match_regs(16'h0000, 8'h00);
          2: write_match_regs(16'hFFFF, 8'hFF);
          default: write_match_regs(16'($urandom), 8'($urandom));
        endcase
      end
      sent = 0;
      while (sent < PHASE_BYTES) begin
        compose_update();
        burst = ($urandom_range(0, 3) == 0);
        foreach (msg_bytes[k]) begin
          send_byte(msg_bytes[k], k == msg_bytes.size() - 1, pick_gap(burst), 1'b0, ST_OK);
        end
        sent += msg_bytes.size();
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
